// ----- hw/rtl/bsq_pkg.sv -----
// Shared constants, codes and control types of the bounded sorted priority queue.
package bsq_pkg;

  localparam int DEPTH_DEF         = 16;
  localparam int KEY_WIDTH_DEF     = 16;
  localparam int PAYLOAD_WIDTH_DEF = 32;

  localparam int OPCODE_W = 2;
  localparam int STATUS_W = 2;
  localparam int PADDR_W  = 3;

  localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_READ   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EVICTED = 2'd2;
  localparam logic [STATUS_W-1:0] ST_ABSENT  = 2'd3;

  // Register index as seen on the word-select bit of paddr.
  localparam logic REG_CAPACITY = 1'b0;

  typedef struct packed {
    logic load;
    logic compare;
    logic commit;
  } cmd_t;

endpackage

// ----- hw/rtl/bsq_datapath.sv -----
// Datapath of the priority queue: entry row, insert position search, update and result register.
module bsq_datapath #(
  parameter int DEPTH         = bsq_pkg::DEPTH_DEF,
  parameter int KEY_WIDTH     = bsq_pkg::KEY_WIDTH_DEF,
  parameter int PAYLOAD_WIDTH = bsq_pkg::PAYLOAD_WIDTH_DEF,
  parameter int IDX_W         = 4,
  parameter int CNT_W         = 5,
  parameter int IN_W          = 54,
  parameter int OUT_W         = 55
) (
  input  logic                clk,
  input  logic                rst,
  input  bsq_pkg::cmd_t       cmd,
  input  logic [CNT_W-1:0]    capacity,
  input  logic [IN_W-1:0]     in_data,
  output logic [OUT_W-1:0]    out_data
);

  localparam int KEY_LO = bsq_pkg::OPCODE_W;
  localparam int PAY_LO = KEY_LO + KEY_WIDTH;
  localparam int IDX_LO = PAY_LO + PAYLOAD_WIDTH;

  logic [bsq_pkg::OPCODE_W-1:0] op_r;
  logic [KEY_WIDTH-1:0]         key_r;
  logic [PAYLOAD_WIDTH-1:0]     pay_r;
  logic [IDX_W-1:0]             idx_r;

  logic [KEY_WIDTH-1:0]     keys [DEPTH];
  logic [PAYLOAD_WIDTH-1:0] pays [DEPTH];
  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         pos;
  logic [CNT_W-1:0]         pos_next;
  logic [DEPTH-1:0]         gt;

  logic [bsq_pkg::STATUS_W-1:0] out_status;
  logic [KEY_WIDTH-1:0]         out_key;
  logic [PAYLOAD_WIDTH-1:0]     out_pay;
  logic [CNT_W-1:0]             out_count;

  logic [CNT_W-1:0]             cap_eff;
  logic [CNT_W-1:0]             idx_ext;
  logic                         full;
  logic                         idx_ok;
  logic                         ins_en;
  logic                         rem_en;
  logic [CNT_W-1:0]             last;
  logic [CNT_W-1:0]             count_next;
  logic [bsq_pkg::STATUS_W-1:0] status;
  logic [KEY_WIDTH-1:0]         rd_key;
  logic [PAYLOAD_WIDTH-1:0]     rd_pay;

  // Every held entry is compared with the new key at once; the first larger one marks the slot.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      gt[i] = (CNT_W'(i) < count) && (keys[i] > key_r);
    end
    pos_next = count;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (gt[i]) begin
        pos_next = CNT_W'(i);
      end
    end
  end

  assign cap_eff = (capacity > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : capacity;
  assign full    = count >= cap_eff;
  assign idx_ext = CNT_W'(idx_r);
  assign idx_ok  = idx_ext < count;

  always_comb begin
    ins_en     = 1'b0;
    rem_en     = 1'b0;
    status     = bsq_pkg::ST_ABSENT;
    rd_key     = '0;
    rd_pay     = '0;
    count_next = count;
    last       = count;
    case (op_r)
      bsq_pkg::OP_INSERT: begin
        if (!full) begin
          ins_en     = 1'b1;
          status     = bsq_pkg::ST_OK;
          count_next = count + CNT_W'(1);
        end else if (pos >= cap_eff) begin
          status = bsq_pkg::ST_FULL;
        end else begin
          ins_en = 1'b1;
          status = bsq_pkg::ST_EVICTED;
          last   = count - CNT_W'(1);
        end
      end
      bsq_pkg::OP_REMOVE: begin
        if (idx_ok) begin
          rem_en     = 1'b1;
          status     = bsq_pkg::ST_OK;
          count_next = count - CNT_W'(1);
        end
      end
      bsq_pkg::OP_READ: begin
        if (idx_ok) begin
          status = bsq_pkg::ST_OK;
          rd_key = keys[idx_r];
          rd_pay = pays[idx_r];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_data[bsq_pkg::OPCODE_W-1:0];
      key_r <= in_data[KEY_LO +: KEY_WIDTH];
      pay_r <= in_data[PAY_LO +: PAYLOAD_WIDTH];
      idx_r <= in_data[IDX_LO +: IDX_W];
    end
    if (cmd.compare) begin
      pos <= pos_next;
    end
    if (cmd.commit) begin
      out_status <= status;
      out_key    <= rd_key;
      out_pay    <= rd_pay;
      out_count  <= count_next;
    end
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) begin
        keys[i] <= '0;
        pays[i] <= '0;
      end
    end else if (cmd.commit) begin
      if (ins_en && pos == '0) begin
        keys[0] <= key_r;
        pays[0] <= pay_r;
      end
      for (int i = 1; i < DEPTH; i++) begin
        if (ins_en && CNT_W'(i) == pos) begin
          keys[i] <= key_r;
          pays[i] <= pay_r;
        end else if (ins_en && CNT_W'(i) > pos && CNT_W'(i) <= last) begin
          keys[i] <= keys[i-1];
          pays[i] <= pays[i-1];
        end
      end
      for (int i = 0; i < DEPTH - 1; i++) begin
        if (rem_en && CNT_W'(i) >= idx_ext && CNT_W'(i + 1) < count) begin
          keys[i] <= keys[i+1];
          pays[i] <= pays[i+1];
        end
      end
      // The slot freed by a removal is cleared.
      for (int i = 0; i < DEPTH; i++) begin
        if (rem_en && CNT_W'(i) == count_next) begin
          keys[i] <= '0;
          pays[i] <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.commit) begin
      count <= count_next;
    end
  end

  assign out_data = {out_count, out_pay, out_key, out_status};

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count exceeds depth");
  a_count_stable: assert property (@(posedge clk) disable iff (rst)
    !cmd.commit |=> $stable(count))
    else $error("entry count changed without a commit");
`endif

endmodule

// ----- hw/rtl/bsq_ctrl.sv -----
// Controller state machine of the priority queue: handshakes and datapath commands.
module bsq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  output logic          m_tvalid,
  input  logic          m_tready,
  output bsq_pkg::cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_COMPARE,
    S_COMMIT
  } state_t;

  state_t state;
  logic   out_valid;
  logic   out_free;

  assign out_free    = !out_valid || m_tready;
  assign s_tready    = state == S_IDLE;
  assign m_tvalid    = out_valid;
  assign cmd.load    = (state == S_IDLE) && s_tvalid;
  assign cmd.compare = state == S_COMPARE;
  assign cmd.commit  = (state == S_COMMIT) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.commit || (out_valid && !m_tready);
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            state <= S_COMPARE;
          end
        end
        S_COMPARE: begin
          state <= S_COMMIT;
        end
        S_COMMIT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.compare, cmd.commit}))
    else $error("more than one datapath command at once");
  a_load_then_compare: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> cmd.compare && !s_tready)
    else $error("accepted transaction was not followed by a compare");
`endif

endmodule

// ----- hw/rtl/bounded_sorted_priority_queue_core.sv -----
// Top level of the bounded sorted priority queue: stream ports, configuration port and wiring.
//
// Input stream (s_t*): one transaction is one operation: insert a key and payload,
// remove the entry at an index, or read the entry at an index (index 0 is the front).
// Output stream (m_t*): one result transaction per operation, carrying the status,
// the key and payload read (zero unless a read succeeded) and the entry count after
// the operation.
// Each operation is captured, then all held keys are compared with the new key in parallel
// to find the insert slot, and then the entry row is shifted and the result register is
// loaded. A new transaction is taken only after the previous operation has committed;
// m_tvalid rises when the result register is loaded at the end of the commit state.
// The result register sits between the two sides, so one operation is accepted while
// an earlier result waits. If the receiver stalls, the finished operation holds in its
// last step until the result register is free, and the input is not ready meanwhile.
// The capacity register is to be written through the APB port only while the queue
// is idle; the user must keep to this, as the core does not enforce it.
// Reset empties the queue and sets the capacity to the built depth.
module bounded_sorted_priority_queue_core #(
  parameter int DEPTH         = bsq_pkg::DEPTH_DEF,
  parameter int KEY_WIDTH     = bsq_pkg::KEY_WIDTH_DEF,
  parameter int PAYLOAD_WIDTH = bsq_pkg::PAYLOAD_WIDTH_DEF,
  localparam int IDX_W        = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W        = $clog2(DEPTH + 1),
  localparam int IN_W         = bsq_pkg::OPCODE_W + KEY_WIDTH + PAYLOAD_WIDTH + IDX_W,
  localparam int OUT_W        = bsq_pkg::STATUS_W + KEY_WIDTH + PAYLOAD_WIDTH + CNT_W,
  localparam int IN_BYTES_W   = ((IN_W + 7) / 8) * 8,
  localparam int OUT_BYTES_W  = ((OUT_W + 7) / 8) * 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // Fields from bit 0 up: opcode, key, payload, index, zero fill.
  input  logic [IN_BYTES_W-1:0]        s_tdata,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // Fields from bit 0 up: status, out_key, out_payload, count, zero fill.
  output logic [OUT_BYTES_W-1:0]       m_tdata,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bsq_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  bsq_pkg::cmd_t    cmd;
  logic [CNT_W-1:0] capacity;
  logic [OUT_W-1:0] out_data;
  logic             reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[bsq_pkg::PADDR_W-1] == bsq_pkg::REG_CAPACITY;
  assign prdata  = reg_sel ? 32'(capacity) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CNT_W'(DEPTH);
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      capacity <= pwdata[CNT_W-1:0];
    end
  end

  bsq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  bsq_datapath #(
    .DEPTH         (DEPTH),
    .KEY_WIDTH     (KEY_WIDTH),
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH),
    .IDX_W         (IDX_W),
    .CNT_W         (CNT_W),
    .IN_W          (IN_W),
    .OUT_W         (OUT_W)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .capacity (capacity),
    .in_data  (s_tdata[IN_W-1:0]),
    .out_data (out_data)
  );

  assign m_tdata = OUT_BYTES_W'(out_data);

endmodule
